// ----- rtl/rsc_pkg.sv -----
`default_nettype none

package rsc_pkg;

    // Fixed field widths of the channels.
    localparam int SYM_BITS       = 8;
    localparam int STATUS_BITS    = 2;
    localparam int RADIX_BITS     = 5;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Alphabets always hold sixteen byte-wide symbols.
    localparam int ALPHA_SIZE     = 16;
    localparam int ALPHA_IDX_BITS = 4;

    // Quotient bits the divider retires per cycle.
    localparam int DIV_STEP_BITS  = 8;

    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [ALPHA_SIZE-1:0][SYM_BITS-1:0] t_alpha;

    // Result status codes.
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_UNKNOWN  = 2'd1;
    localparam t_status STATUS_OVERFLOW = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_BASE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TO_BASE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_LOW  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_HIGH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TO_LOW    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TO_HIGH   = 3'd5;

    // Reset values of the radix registers.
    localparam logic [RADIX_BITS-1:0] FROM_BASE_RESET = 5'd10;
    localparam logic [RADIX_BITS-1:0] TO_BASE_RESET   = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic acc;
        logic div_init;
        logic div_step;
        logic digit_write;
        logic rd;
        logic load_digit;
        logic load_err;
        logic clear;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic err_any;
        logic quot_zero;
        logic count_full;
        logic ptr_zero;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/rsc_if.sv -----
`default_nettype none

// Input symbol channel.
interface rsc_in_if;
    import rsc_pkg::*;
    logic                valid;
    logic                ready;
    logic [SYM_BITS-1:0] in_symbol;
    logic                in_last;
    modport source (output valid, output in_symbol, output in_last, input ready);
    modport sink   (input valid, input in_symbol, input in_last, output ready);
endinterface

// Output symbol channel.
interface rsc_out_if;
    import rsc_pkg::*;
    logic                valid;
    logic                ready;
    logic [SYM_BITS-1:0] out_symbol;
    logic                out_last;
    t_status             out_status;
    modport source (output valid, output out_symbol, output out_last, output out_status,
                    input ready);
    modport sink   (input valid, input out_symbol, input out_last, input out_status,
                    output ready);
endinterface

// Configuration write channel.
interface rsc_cfg_if;
    import rsc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/radix_string_converter.sv -----
// Radix string converter.
// Symbols of a number arrive on i_in one request at a time, most significant
// first, with in_last on the final symbol. Each symbol is looked up in the
// source alphabet and folded into the accumulator. After the final symbol the
// value is sent on o_out in the target alphabet, most significant first, with
// out_last on the final symbol. An unknown symbol or an overflow gives one
// result with out_symbol zero and out_status set.
// Configuration writes arrive on i_cfg; the user must make them only while the
// block is idle, which the block itself does not enforce. Each symbol is
// captured and then accumulated; after the final symbol each target digit is
// made by the divider, which retires 8 quotient bits a cycle, and stored, and
// the digits are then read back from the digit RAM and sent.
// When the receiver stalls, the output register holds its request and the
// block waits; a new symbol is still taken while the last result waits.
// A synchronous reset clears the accumulator, the error flags and the output
// valid flag and restores the register reset values.
`default_nettype none

module radix_string_converter #(
    parameter int MAX_RADIX      = 16,
    parameter int VALUE_BITS     = 32,
    parameter int MAX_OUT_DIGITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsc_in_if.sink     i_in,
    rsc_out_if.source  o_out,
    rsc_cfg_if.sink    i_cfg
);

    import rsc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    rsc_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    rsc_dp #(
        .MAX_RADIX      (MAX_RADIX),
        .VALUE_BITS     (VALUE_BITS),
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_symbol  (i_in.in_symbol),
        .i_in_last    (i_in.in_last),
        .i_cfg_wr     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_symbol (o_out.out_symbol),
        .o_out_last   (o_out.out_last),
        .o_out_status (o_out.out_status)
    );

endmodule

`default_nettype wire

// ----- rtl/rsc_ram.sv -----
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/rsc_ctrl.sv -----
`default_nettype none

module rsc_ctrl #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output rsc_pkg::t_dp_cmd       o_cmd,
    input  wire rsc_pkg::t_dp_stat i_stat
);

    import rsc_pkg::*;

    localparam int DIV_CYCLES    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int STEP_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [STEP_CNT_BITS-1:0] STEP_LAST = STEP_CNT_BITS'(DIV_CYCLES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CHECK,
        S_DIV,
        S_WRITE,
        S_RD,
        S_LOAD,
        S_ERR
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [STEP_CNT_BITS-1:0] r_step;
    logic [STEP_CNT_BITS-1:0] n_step;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                if (i_stat.err_any) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_step         = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_step  = '0;
                    n_state = S_WRITE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.digit_write = 1'b1;
                if (i_stat.quot_zero) begin
                    n_state = S_RD;
                end else if (i_stat.count_full) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_digit = 1'b1;
                if (i_stat.out_free) begin
                    if (i_stat.ptr_zero) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_ERR: begin
                o_cmd.load_err = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsc_dp.sv -----
`default_nettype none

module rsc_dp #(
    parameter int MAX_RADIX      = 16,
    parameter int VALUE_BITS     = 32,
    parameter int MAX_OUT_DIGITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsc_pkg::t_dp_cmd              i_cmd,
    output rsc_pkg::t_dp_stat                  o_stat,
    input  wire logic [rsc_pkg::SYM_BITS-1:0]  i_in_symbol,
    input  wire logic                          i_in_last,
    input  wire logic                          i_cfg_wr,
    input  wire logic [rsc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [rsc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [rsc_pkg::SYM_BITS-1:0]  o_out_symbol,
    output logic                               o_out_last,
    output rsc_pkg::t_status                   o_out_status
);

    import rsc_pkg::*;

    localparam int DIGIT_BITS = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int ADDR_BITS  = $clog2(MAX_OUT_DIGITS);
    localparam int PROD_BITS  = VALUE_BITS + RADIX_BITS;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_BITS   = DIV_CYCLES * DIV_STEP_BITS;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(MAX_RADIX);
    localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
    localparam logic [ADDR_BITS-1:0]  COUNT_TOP = ADDR_BITS'(MAX_OUT_DIGITS - 1);

    // Configuration registers.
    logic [RADIX_BITS-1:0] r_from_base;
    logic [RADIX_BITS-1:0] r_to_base;
    t_alpha                r_from_alpha;
    t_alpha                r_to_alpha;

    // Accumulation state.
    logic [VALUE_BITS-1:0]     r_acc;
    logic [1:0]                r_err;
    logic [ALPHA_IDX_BITS-1:0] r_idx;
    logic                      r_found;
    logic                      r_last;

    // Conversion state.
    logic [PAD_BITS-1:0]   r_div;
    logic [DIGIT_BITS-1:0] r_rem;
    logic [ADDR_BITS-1:0]  r_count;
    logic [ADDR_BITS-1:0]  r_ptr;

    // Output register.
    logic                r_out_valid;
    logic [SYM_BITS-1:0] r_out_symbol;
    logic                r_out_last;
    t_status             r_out_status;

    logic [RADIX_BITS-1:0]     w_from_base;
    logic [RADIX_BITS-1:0]     w_to_base;
    logic [ALPHA_IDX_BITS-1:0] w_idx;
    logic                      w_found;
    logic [PROD_BITS-1:0]      w_prod;
    logic                      w_ovf;
    logic [RADIX_BITS:0]       w_part;
    logic [DIV_STEP_BITS-1:0]  w_qbits;
    logic [DIGIT_BITS-1:0]     w_rem_next;
    logic [DIGIT_BITS-1:0]     w_rd_digit;
    logic                      w_out_free;

    // Radix registers clamped to the supported range.
    always_comb begin
        if (r_from_base < RADIX_MIN) begin
            w_from_base = RADIX_MIN;
        end else if (r_from_base > RADIX_MAX) begin
            w_from_base = RADIX_MAX;
        end else begin
            w_from_base = r_from_base;
        end
        if (r_to_base < RADIX_MIN) begin
            w_to_base = RADIX_MIN;
        end else if (r_to_base > RADIX_MAX) begin
            w_to_base = RADIX_MAX;
        end else begin
            w_to_base = r_to_base;
        end
    end

    // Source symbol search; the lowest matching position below the radix wins.
    always_comb begin
        w_idx   = '0;
        w_found = 1'b0;
        for (int k = ALPHA_SIZE - 1; k >= 0; k--) begin
            if ((r_from_alpha[k] == i_in_symbol) &&
                (RADIX_BITS'(k) < w_from_base)) begin
                w_idx   = ALPHA_IDX_BITS'(k);
                w_found = 1'b1;
            end
        end
    end

    // Multiply-accumulate with overflow detection above the value width.
    assign w_prod = PROD_BITS'(r_acc) * PROD_BITS'(w_from_base) + PROD_BITS'(r_idx);
    assign w_ovf  = |w_prod[PROD_BITS-1:VALUE_BITS];

    // Long division by the target radix, several quotient bits per cycle.
    always_comb begin
        w_part  = (RADIX_BITS + 1)'(r_rem);
        w_qbits = '0;
        for (int j = 0; j < DIV_STEP_BITS; j++) begin
            w_part = {w_part[RADIX_BITS-1:0], r_div[PAD_BITS-1-j]};
            if (w_part >= (RADIX_BITS + 1)'(w_to_base)) begin
                w_part                     = w_part - (RADIX_BITS + 1)'(w_to_base);
                w_qbits[DIV_STEP_BITS-1-j] = 1'b1;
            end
        end
        w_rem_next = w_part[DIGIT_BITS-1:0];
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_base  <= FROM_BASE_RESET;
            r_to_base    <= TO_BASE_RESET;
            r_from_alpha <= '0;
            r_to_alpha   <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                REG_FROM_BASE: r_from_base <= i_cfg_data[RADIX_BITS-1:0];
                REG_TO_BASE:   r_to_base   <= i_cfg_data[RADIX_BITS-1:0];
                REG_FROM_LOW:  r_from_alpha[ALPHA_SIZE/2-1:0] <= i_cfg_data;
                REG_FROM_HIGH: r_from_alpha[ALPHA_SIZE-1:ALPHA_SIZE/2] <= i_cfg_data;
                REG_TO_LOW:    r_to_alpha[ALPHA_SIZE/2-1:0] <= i_cfg_data;
                REG_TO_HIGH:   r_to_alpha[ALPHA_SIZE-1:ALPHA_SIZE/2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accumulator and error flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= '0;
        end else if (i_cmd.clear) begin
            r_acc <= '0;
            r_err <= '0;
        end else if (i_cmd.acc) begin
            if (!r_found) begin
                r_err[0] <= 1'b1;
            end else begin
                r_acc <= w_prod[VALUE_BITS-1:0];
                if (w_ovf) begin
                    r_err[1] <= 1'b1;
                end
            end
        end else if (i_cmd.digit_write && !o_stat.quot_zero && o_stat.count_full) begin
            r_err[1] <= 1'b1;
        end
    end

    // Captured symbol lookup.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx   <= w_idx;
            r_found <= w_found;
            r_last  <= i_in_last;
        end
    end

    // Divider, digit count and read pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div   <= PAD_BITS'(r_acc);
            r_rem   <= '0;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= PAD_BITS'({r_div, w_qbits});
            r_rem <= w_rem_next;
        end else if (i_cmd.digit_write) begin
            r_rem   <= '0;
            r_count <= r_count + 1'b1;
            r_ptr   <= r_count;
        end else if (i_cmd.load_digit && w_out_free) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    // Digits are stored least significant first and read back in reverse.
    rsc_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (MAX_OUT_DIGITS)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.digit_write),
        .i_wr_addr (r_count),
        .i_wr_data (r_rem),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_rd_digit)
    );

    // Output register; it holds a request until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.load_digit || i_cmd.load_err) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_digit && w_out_free) begin
            r_out_symbol <= r_to_alpha[ALPHA_IDX_BITS'(w_rd_digit)];
            r_out_last   <= (r_ptr == '0);
            r_out_status <= STATUS_OK;
        end else if (i_cmd.load_err && w_out_free) begin
            r_out_symbol <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= r_err[0] ? STATUS_UNKNOWN : STATUS_OVERFLOW;
        end
    end

    assign o_stat.last       = r_last;
    assign o_stat.err_any    = |r_err;
    assign o_stat.quot_zero  = (r_div == '0);
    assign o_stat.count_full = (r_count == COUNT_TOP);
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out_symbol;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire
